[design/fspa_pkg.sv]
// Package: shared types, constants and codes for the flat-shaded primitive assembler.
`timescale 1ns / 1ps
`default_nettype none
package fspa_pkg;
    localparam int INDEX_WIDTH_DEF = 16;
    localparam int COORD_WIDTH_DEF = 16;
    localparam int P_W = 48;
    localparam int COLOR_W = 32;
    localparam int LANE_W = 16;

    localparam logic [1:0] CMD_TRI   = 2'd0;
    localparam logic [1:0] CMD_QUAD  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_NORM,
        ST_SQRT,
        ST_DIV,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic norm_step;
        logic sqrt_init;
        logic sqrt_step;
        logic div_init;
        logic div_step;
        logic out_load;
        logic [2:0] out_sel;
        logic out_last;
    } cmd_t;

    typedef struct packed {
        logic zero;
        logic norm_done;
        logic sqrt_done;
        logic div_done;
    } stat_t;
endpackage
`default_nettype wire

[design/flat_shaded_primitive_assembler_top.sv]
// Top level: stream wrapper joining the controller and datapath.
// A primitive passes through the normalize load, the normalize shift steps, three
// square sums and the bit-serial root steps, then a divide for each of the three lanes;
// a degenerate face skips the root and divide and goes straight to its result beats.
// One primitive at a time: the next beat is taken the cycle after the last result
// is loaded. Clear and unknown commands are taken in the idle state without leaving it.
// Reset: rst_n async active low clears the vertex count and the sequencer.
`timescale 1ns / 1ps
`default_nettype none
module flat_shaded_primitive_assembler_top
#(
    parameter int INDEX_WIDTH = fspa_pkg::INDEX_WIDTH_DEF,
    parameter int COORD_WIDTH = fspa_pkg::COORD_WIDTH_DEF
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // point_a, point_b, point_c, point_d, shade
    input  wire logic [223:0] s_tdata,
    // cmd
    input  wire logic [1:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // vertex_number, position, vertex_color, face_normal, index_first/second/third
    output logic [191:0]      m_tdata,
    // kind
    output logic              m_tuser,
    output logic              m_tlast
);
    import fspa_pkg::*;

    cmd_t  cm;
    stat_t st;
    logic  in_fire, out_take, out_free;

    assign in_fire  = s_tvalid && s_tready;
    assign out_take = m_tvalid && m_tready;
    assign out_free = !m_tvalid || m_tready;

    fspa_ctrl u_ctrl
    (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .in_cmd(s_tuser),
        .out_free(out_free), .st(st), .cm(cm), .in_ready(s_tready)
    );

    fspa_datapath #(.INDEX_WIDTH(INDEX_WIDTH), .COORD_WIDTH(COORD_WIDTH)) u_dp
    (
        .clk(clk), .rst_n(rst_n), .cm(cm),
        .clear(in_fire && s_tuser == CMD_CLEAR),
        .pa(s_tdata[47:0]), .pb(s_tdata[95:48]), .pc(s_tdata[143:96]),
        .pd(s_tdata[191:144]), .color(s_tdata[223:192]),
        .out_take(out_take), .st(st), .out_valid(m_tvalid),
        .out_data(m_tdata), .out_kind(m_tuser), .out_last(m_tlast)
    );

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=>
            m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast));
    a_triple_fields: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[143:0] == '0);
    a_vertex_fields: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata[191:144] == '0);
    a_last_on_triple: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tuser);
endmodule
`default_nettype wire

[design/fspa_ctrl.sv]
// Controller: sequences normalization, root, divide and result beats.
`timescale 1ns / 1ps
`default_nettype none
module fspa_ctrl
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_fire,
    input  wire logic [1:0]     in_cmd,
    input  wire logic           out_free,
    input  wire fspa_pkg::stat_t st,
    output fspa_pkg::cmd_t      cm,
    output logic                in_ready
);
    import fspa_pkg::*;

    state_t state_reg, state_next;
    logic   quad_reg, quad_next;
    logic [2:0] beat_reg, beat_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            quad_reg  <= 1'b0;
            beat_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            quad_reg  <= quad_next;
            beat_reg  <= beat_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        quad_next  = quad_reg;
        beat_next  = beat_reg;
        cm         = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_fire && (in_cmd == CMD_TRI || in_cmd == CMD_QUAD))
                begin
                    cm.load    = 1'b1;
                    quad_next  = (in_cmd == CMD_QUAD);
                    state_next = ST_NORM;
                end
            end
            ST_NORM:
            begin
                if (st.zero)
                begin
                    beat_next  = '0;
                    state_next = ST_EMIT;
                end
                else if (st.norm_done)
                begin
                    cm.sqrt_init = 1'b1;
                    state_next   = ST_SQRT;
                end
                else
                    cm.norm_step = 1'b1;
            end
            ST_SQRT:
            begin
                if (st.sqrt_done)
                begin
                    cm.div_init = 1'b1;
                    state_next  = ST_DIV;
                end
                else
                    cm.sqrt_step = 1'b1;
            end
            ST_DIV:
            begin
                if (st.div_done)
                begin
                    beat_next  = '0;
                    state_next = ST_EMIT;
                end
                else
                    cm.div_step = 1'b1;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    cm.out_load = 1'b1;
                    // out_sel 0..3 vertices, 4 first triple, 5 second triple; a triangle ends with 4 at beat 3
                    if (!quad_reg && beat_reg == 3'd3)
                        cm.out_sel = 3'd4;
                    else if (quad_reg && beat_reg == 3'd5)
                        cm.out_sel = 3'd5;
                    else
                        cm.out_sel = beat_reg;
                    cm.out_last = (quad_reg && beat_reg == 3'd5) ||
                                  (!quad_reg && beat_reg == 3'd3);
                    beat_next = beat_reg + 3'd1;
                    if (cm.out_last)
                        state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

[design/fspa_datapath.sv]
// Datapath: cross product, normalize shift, bit-serial root and divider, result register.
`timescale 1ns / 1ps
`default_nettype none
module fspa_datapath
#(
    parameter int INDEX_WIDTH = fspa_pkg::INDEX_WIDTH_DEF,
    parameter int COORD_WIDTH = fspa_pkg::COORD_WIDTH_DEF
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire fspa_pkg::cmd_t              cm,
    input  wire logic                        clear,
    input  wire logic [fspa_pkg::P_W-1:0]    pa,
    input  wire logic [fspa_pkg::P_W-1:0]    pb,
    input  wire logic [fspa_pkg::P_W-1:0]    pc,
    input  wire logic [fspa_pkg::P_W-1:0]    pd,
    input  wire logic [fspa_pkg::COLOR_W-1:0] color,
    input  wire logic                        out_take,
    output fspa_pkg::stat_t                  st,
    output logic                             out_valid,
    output logic [191:0]                     out_data,
    output logic                             out_kind,
    output logic                             out_last
);
    import fspa_pkg::*;

    localparam int DW = COORD_WIDTH + 1;
    localparam int NW = 2 * DW + 1;
    localparam int AW = (NW > 30) ? NW : 30;
    localparam int SW = 63;

    logic [P_W-1:0] pt_reg [4];
    logic [COLOR_W-1:0] color_reg;
    logic [2:0] neg_reg;
    logic [NW-1:0] mag_reg [3];
    logic [AW-1:0] a_reg [3];
    logic [SW-1:0] s_reg;
    logic [63:0] rem_reg, res_reg, bit_reg;
    logic [30:0] len_reg;
    logic [1:0] lane_reg;
    logic [5:0] dcnt_reg;
    logic [45:0] drem_reg;
    logic [15:0] q_reg;
    logic [15:0] nrm_reg [3];
    logic [INDEX_WIDTH-1:0] cnt_reg;
    logic [INDEX_WIDTH-1:0] base_reg;
    logic phase_reg;
    logic [1:0] sq_reg;

    function automatic logic signed [DW-1:0] crd(input logic [P_W-1:0] p, input int l);
        logic [LANE_W-1:0] v;
        v = p[l*LANE_W +: LANE_W];
        return DW'($signed(v[COORD_WIDTH-1:0]));
    endfunction

    logic signed [DW-1:0] u [3], v [3];
    logic signed [NW-1:0] n [3];
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            u[i] = crd(pc, i) - crd(pa, i);
            v[i] = crd(pc, i) - crd(pb, i);
        end
        n[0] = NW'(u[1] * v[2]) - NW'(u[2] * v[1]);
        n[1] = NW'(u[2] * v[0]) - NW'(u[0] * v[2]);
        n[2] = NW'(u[0] * v[1]) - NW'(u[1] * v[0]);
    end

    logic [NW-1:0] mx;
    always_comb
    begin
        mx = mag_reg[0];
        if (mag_reg[1] > mx) mx = mag_reg[1];
        if (mag_reg[2] > mx) mx = mag_reg[2];
    end

    logic [AW-1:0] a_or;
    assign a_or = a_reg[0] | a_reg[1] | a_reg[2];

    assign st.zero      = phase_reg && (mx == '0);
    assign st.norm_done = !phase_reg && a_or != '0 && (a_or >> 29) == AW'(1);
    assign st.sqrt_done = (bit_reg == '0) && (sq_reg == 2'd3);
    assign st.div_done  = (lane_reg == 2'd3);

    logic [29:0] am;
    logic [59:0] sq;
    assign am = a_reg[sq_reg][29:0];
    assign sq = am * am;

    logic [63:0] rb;
    assign rb = res_reg + bit_reg;

    always_ff @(posedge clk)
    begin
        if (cm.load)
        begin
            pt_reg[0] <= pa; pt_reg[1] <= pb; pt_reg[2] <= pc; pt_reg[3] <= pd;
            color_reg <= color;
            phase_reg <= 1'b1;
            for (int i = 0; i < 3; i++)
            begin
                neg_reg[i] <= n[i][NW-1];
                mag_reg[i] <= n[i][NW-1] ? NW'(-n[i]) : n[i];
                nrm_reg[i] <= '0;
            end
        end
        if (cm.norm_step)
        begin
            if (phase_reg)
            begin
                phase_reg <= 1'b0;
                for (int i = 0; i < 3; i++) a_reg[i] <= AW'(mag_reg[i]);
            end
            else if ((mx >> 0) != '0 && (a_or >> 30) != '0)
                for (int i = 0; i < 3; i++) a_reg[i] <= a_reg[i] >> 1;
            else
                for (int i = 0; i < 3; i++) a_reg[i] <= a_reg[i] << 1;
        end
        if (cm.sqrt_init)
        begin
            s_reg  <= '0;
            sq_reg <= '0;
            rem_reg <= '0;
            res_reg <= '0;
            bit_reg <= '0;
        end
        if (cm.sqrt_step)
        begin
            if (sq_reg != 2'd3)
            begin
                s_reg  <= s_reg + SW'(sq);
                sq_reg <= sq_reg + 2'd1;
                if (sq_reg == 2'd2)
                begin
                    rem_reg <= 64'(s_reg + SW'(sq));
                    bit_reg <= 64'd1 << 62;
                end
            end
            else
            begin
                if (rem_reg >= rb)
                begin
                    rem_reg <= rem_reg - rb;
                    res_reg <= (res_reg >> 1) + bit_reg;
                end
                else
                    res_reg <= res_reg >> 1;
                bit_reg <= bit_reg >> 2;
            end
        end
        if (cm.div_init)
        begin
            len_reg  <= res_reg[30:0];
            lane_reg <= '0;
            dcnt_reg <= '0;
        end
        if (cm.div_step)
        begin
            if (dcnt_reg == 6'd0)
            begin
                drem_reg <= (46'(a_reg[lane_reg]) << 14) + 46'(len_reg >> 1);
                q_reg    <= '0;
                dcnt_reg <= 6'd1;
            end
            else if (dcnt_reg <= 6'd16)
            begin
                // restoring divide on quotient bits 15..0 of ((a << 14) + len / 2) / len
                dcnt_reg <= dcnt_reg + 6'd1;
                if (drem_reg >= (46'(len_reg) << (16 - dcnt_reg)))
                begin
                    drem_reg <= drem_reg - (46'(len_reg) << (16 - dcnt_reg));
                    q_reg <= q_reg | (16'd1 << (16 - dcnt_reg));
                end
            end
            else
            begin
                nrm_reg[lane_reg] <= neg_reg[lane_reg] ?
                    16'(17'h10000 - {1'b0, (q_reg > 16'd16384) ? 16'd16384 : q_reg}) :
                    ((q_reg > 16'd16384) ? 16'd16384 : q_reg);
                lane_reg <= lane_reg + 2'd1;
                dcnt_reg <= '0;
            end
        end
    end

    logic [INDEX_WIDTH-1:0] idx [4];
    always_comb
        for (int i = 0; i < 4; i++) idx[i] = base_reg + INDEX_WIDTH'(i);

    logic [15:0] nv [4];
    always_comb
        for (int i = 0; i < 4; i++) nv[i] = 16'(idx[i]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            base_reg  <= '0;
            out_valid <= 1'b0;
        end
        else
        begin
            if (clear) cnt_reg <= '0;
            if (cm.load) base_reg <= cnt_reg;
            if (cm.out_load)
            begin
                out_valid <= 1'b1;
                if (cm.out_last)
                    cnt_reg <= base_reg + INDEX_WIDTH'(cm.out_sel == 3'd5 ? 4 : 3);
            end
            else if (out_take)
                out_valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cm.out_load)
        begin
            out_last <= cm.out_last;
            out_kind <= cm.out_sel >= 3'd4;
            case (cm.out_sel)
                3'd4: out_data <= {nv[2], nv[1], nv[0], 48'd0, 32'd0, 48'd0, 16'd0};
                3'd5: out_data <= {nv[3], nv[2], nv[0], 48'd0, 32'd0, 48'd0, 16'd0};
                default: out_data <= {48'd0, nrm_reg[2], nrm_reg[1], nrm_reg[0],
                                      color_reg, pt_reg[cm.out_sel[1:0]],
                                      nv[cm.out_sel[1:0]]};
            endcase
        end
    end
endmodule
`default_nettype wire
